@@ hw/rtl/mtb_pkg.sv @@
// Shared types, event codes and state encodings for the multitouch slot reframer.
package mtb_pkg;

  localparam logic [15:0] T_SYN = 16'h0000;
  localparam logic [15:0] T_KEY = 16'h0001;
  localparam logic [15:0] T_ABS = 16'h0003;

  localparam logic [15:0] C_SYN_REPORT = 16'h0000;
  localparam logic [15:0] C_SLOT       = 16'h002f;
  localparam logic [15:0] C_MAJOR      = 16'h0030;
  localparam logic [15:0] C_PX         = 16'h0035;
  localparam logic [15:0] C_PY         = 16'h0036;
  localparam logic [15:0] C_TRACK      = 16'h0039;
  localparam logic [15:0] C_PRESS      = 16'h003a;
  localparam logic [15:0] C_BTN_TOUCH  = 16'h014a;
  localparam logic [15:0] C_BTN_FINGER = 16'h0145;

  localparam logic [31:0] TRACK_NONE = 32'hffff_ffff;

  localparam int          BEAT_W          = 3;
  localparam logic [BEAT_W-1:0] SB_SLOT   = 3'd0;
  localparam logic [BEAT_W-1:0] SB_TRACK  = 3'd1;
  localparam logic [BEAT_W-1:0] SB_PX     = 3'd2;
  localparam logic [BEAT_W-1:0] SB_PY     = 3'd3;
  localparam logic [BEAT_W-1:0] SB_MAJOR  = 3'd4;
  localparam logic [BEAT_W-1:0] SB_PRESS  = 3'd5;
  localparam logic [BEAT_W-1:0] KB_TOUCH  = 3'd0;
  localparam logic [BEAT_W-1:0] KB_FINGER = 3'd1;

  localparam logic REQ_PARSE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    FL_IDLE,
    FL_SCAN,
    FL_EMIT,
    FL_FINISH,
    FL_KEY,
    FL_SYN
  } flush_state_t;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } ev_beat_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic trk;
    logic x;
    logic y;
  } ram_we_t;

endpackage

@@ hw/rtl/mtb_ev_if.sv @@
// Input event channel: valid, ready and one event beat.
interface mtb_ev_if import mtb_pkg::*; ();
  logic     valid;
  logic     ready;
  ev_beat_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/mtb_out_if.sv @@
// Output event channel: valid, ready and one reframed event beat.
interface mtb_out_if import mtb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/mtb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mtb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/mtb_parser.sv @@
// Event parser: current slot, per-slot flags and field writes into the slot RAMs.
module mtb_parser import mtb_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  ev_beat_t                              beat,
  input  logic                                  clr_touched,
  output logic [SLOTS-1:0]                      active,
  output logic [SLOTS-1:0]                      touched,
  output logic [SLOTS-1:0]                      trk_wr,
  output logic [SLOTS-1:0]                      x_wr,
  output logic [SLOTS-1:0]                      y_wr,
  output ram_we_t                               we,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] wr_addr
);

  localparam int          IW      = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [31:0] SLOTS_V = 32'(SLOTS);

  logic [IW-1:0] cur;
  logic          abs_ev;
  logic          slot_ev;
  logic          field_ev;

  assign abs_ev   = fire && (beat.req_type == REQ_PARSE) && (beat.ev_type == T_ABS);
  assign slot_ev  = abs_ev && (beat.ev_code == C_SLOT);
  assign field_ev = abs_ev && (beat.ev_code != C_SLOT);

  assign we.trk  = field_ev && (beat.ev_code == C_TRACK);
  assign we.x    = field_ev && (beat.ev_code == C_PX);
  assign we.y    = field_ev && (beat.ev_code == C_PY);
  assign wr_addr = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      active  <= '0;
      touched <= '0;
      trk_wr  <= '0;
      x_wr    <= '0;
      y_wr    <= '0;
    end else begin
      if (slot_ev && ($unsigned(beat.ev_value) < SLOTS_V)) begin
        cur <= beat.ev_value[IW-1:0];
      end
      if (clr_touched) begin
        touched <= '0;
      end else if (field_ev) begin
        touched[cur] <= 1'b1;
      end
      if (we.trk) begin
        trk_wr[cur] <= 1'b1;
        active[cur] <= ($unsigned(beat.ev_value) != TRACK_NONE);
      end
      if (we.x) begin
        x_wr[cur]   <= 1'b1;
        active[cur] <= 1'b1;
      end
      if (we.y) begin
        y_wr[cur]   <= 1'b1;
        active[cur] <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mtb_flush.sv @@
// Flush sequencer: walks all slots, reads the slot RAMs for touched ones and drives the output register.
module mtb_flush import mtb_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [SLOTS-1:0]                      active,
  input  logic [SLOTS-1:0]                      touched,
  input  logic [SLOTS-1:0]                      trk_wr,
  input  logic [SLOTS-1:0]                      x_wr,
  input  logic [SLOTS-1:0]                      y_wr,
  input  logic [31:0]                           trk_data,
  input  logic [31:0]                           x_data,
  input  logic [31:0]                           y_data,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output logic                                  busy,
  output logic                                  clr_touched,
  mtb_out_if.source                             reframed
);

  localparam int            IW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  flush_state_t      state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [BEAT_W-1:0] beat, beat_next;
  logic              finger_down, finger_down_next;
  logic              ovalid;
  out_beat_t         obeat, obeat_next;
  logic              load;
  logic              room;
  logic              any;
  logic [31:0]       press;
  logic [31:0]       trk_val;
  logic [31:0]       x_val;
  logic [31:0]       y_val;

  assign room    = !ovalid || reframed.ready;
  assign any     = |active;
  assign press   = {31'd0, active[idx]};
  assign trk_val = trk_wr[idx] ? trk_data : TRACK_NONE;
  assign x_val   = x_wr[idx] ? x_data : 32'd0;
  assign y_val   = y_wr[idx] ? y_data : 32'd0;
  assign rd_addr = idx;
  assign busy    = (state != FL_IDLE);

  assign reframed.valid = ovalid;
  assign reframed.data  = obeat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FL_IDLE;
      idx         <= '0;
      beat        <= '0;
      finger_down <= 1'b0;
      ovalid      <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      beat        <= beat_next;
      finger_down <= finger_down_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (reframed.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obeat <= obeat_next;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    beat_next        = beat;
    finger_down_next = finger_down;
    load             = 1'b0;
    clr_touched      = 1'b0;
    obeat_next       = '{out_type: T_ABS, out_code: C_SLOT, out_value: '0, last: 1'b0};
    case (state)
      FL_IDLE: begin
        if (start) begin
          state_next = FL_SCAN;
          idx_next   = '0;
        end
      end
      FL_SCAN: begin
        if (touched[idx]) begin
          state_next = FL_EMIT;
          beat_next  = SB_SLOT;
        end else if (idx == LAST) begin
          state_next = FL_FINISH;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      FL_EMIT: begin
        case (beat)
          SB_SLOT: begin
            obeat_next.out_code  = C_SLOT;
            obeat_next.out_value = {{(32-IW){1'b0}}, idx};
          end
          SB_TRACK: begin
            obeat_next.out_code  = C_TRACK;
            obeat_next.out_value = trk_val;
          end
          SB_PX: begin
            obeat_next.out_code  = C_PX;
            obeat_next.out_value = x_val;
          end
          SB_PY: begin
            obeat_next.out_code  = C_PY;
            obeat_next.out_value = y_val;
          end
          SB_MAJOR: begin
            obeat_next.out_code  = C_MAJOR;
            obeat_next.out_value = press;
          end
          default: begin
            obeat_next.out_code  = C_PRESS;
            obeat_next.out_value = press;
          end
        endcase
        if (room) begin
          load = 1'b1;
          if (beat == SB_PRESS) begin
            if (idx == LAST) begin
              state_next = FL_FINISH;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = FL_SCAN;
            end
          end else begin
            beat_next = beat + BEAT_W'(1);
          end
        end
      end
      FL_FINISH: begin
        beat_next  = KB_TOUCH;
        state_next = (any != finger_down) ? FL_KEY : FL_SYN;
      end
      FL_KEY: begin
        obeat_next.out_type  = T_KEY;
        obeat_next.out_code  = (beat == KB_TOUCH) ? C_BTN_TOUCH : C_BTN_FINGER;
        obeat_next.out_value = {31'd0, any};
        if (room) begin
          load = 1'b1;
          if (beat == KB_FINGER) begin
            finger_down_next = any;
            state_next       = FL_SYN;
          end else begin
            beat_next = KB_FINGER;
          end
        end
      end
      FL_SYN: begin
        obeat_next = '{out_type: T_SYN, out_code: C_SYN_REPORT, out_value: '0, last: 1'b1};
        if (room) begin
          load        = 1'b1;
          clr_touched = 1'b1;
          state_next  = FL_IDLE;
        end
      end
      default: begin
        state_next = FL_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/mt_b_slot_tracker_reframer_top.sv @@
// Top level of the multitouch protocol B slot tracker and reframer.
//
// The events channel takes one beat per input item: a parse request carries
// one input event, a flush request asks for the reframed batch. Parse beats
// are accepted one per cycle while no flush is running and produce no
// output; they update the current slot, the per-slot flags and the slot
// RAMs holding tracking id, x and y. A flush beat starts a walk over all
// slots, skipping untouched ones. Each touched slot gets a RAM read and
// six output beats. The finish step decides on the optional key pair of
// two beats; the closing sync report is one beat flagged with last.
// The events channel is not ready while a flush is running; the next item is
// taken as soon as the closing sync report is in the output register.
// A stalled receiver holds the output register and pauses the walk.
// Reset clears the flags, the current slot and the finger state; RAM
// entries never written read back as their reset values through per-entry
// written bits, so no clearing pass is needed.
module mt_b_slot_tracker_reframer_top import mtb_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic       clk,
  input  logic       rst,
  mtb_ev_if.sink     events,
  mtb_out_if.source  reframed
);

  localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic             fire;
  logic             start;
  logic             busy;
  logic             clr_touched;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] touched;
  logic [SLOTS-1:0] trk_wr;
  logic [SLOTS-1:0] x_wr;
  logic [SLOTS-1:0] y_wr;
  ram_we_t          we;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;
  logic [31:0]      trk_data;
  logic [31:0]      x_data;
  logic [31:0]      y_data;
  logic [31:0]      wr_data;

  assign events.ready = !busy;
  assign fire         = events.valid && events.ready;
  assign start        = fire && (events.data.req_type == REQ_FLUSH);
  assign wr_data      = events.data.ev_value;

  mtb_parser #(.SLOTS(SLOTS)) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .beat        (events.data),
    .clr_touched (clr_touched),
    .active      (active),
    .touched     (touched),
    .trk_wr      (trk_wr),
    .x_wr        (x_wr),
    .y_wr        (y_wr),
    .we          (we),
    .wr_addr     (wr_addr)
  );

  mtb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_trk_ram (
    .clk     (clk),
    .wr_en   (we.trk),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (trk_data)
  );

  mtb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_x_ram (
    .clk     (clk),
    .wr_en   (we.x),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (x_data)
  );

  mtb_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_y_ram (
    .clk     (clk),
    .wr_en   (we.y),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (y_data)
  );

  mtb_flush #(.SLOTS(SLOTS)) u_flush (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .active      (active),
    .touched     (touched),
    .trk_wr      (trk_wr),
    .x_wr        (x_wr),
    .y_wr        (y_wr),
    .trk_data    (trk_data),
    .x_data      (x_data),
    .y_data      (y_data),
    .rd_addr     (rd_addr),
    .busy        (busy),
    .clr_touched (clr_touched),
    .reframed    (reframed)
  );

`ifndef SYNTH
  a_flush_starts: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("Accepted flush request did not start the slot walk.");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(we.trk || we.x || we.y))
    else $error("Slot RAM written while a flush is running.");

  a_touched_cleared: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (touched == '0))
    else $error("Touched flags not cleared at the end of a flush.");
`endif

endmodule

@@ tb/mtb_reframe_check.sv @@
`timescale 1ns / 100ps
// Slot tracking predictor and beat comparison for the multitouch reframer testbench.
module mtb_reframe_check import mtb_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic clk,
  input  logic rst,
  mtb_ev_if    ev,
  mtb_out_if   rf,
  output int   fail_count,
  output int   outstanding
);

  logic        active_q  [SLOTS];
  logic        touched_q [SLOTS];
  logic [31:0] track_q   [SLOTS];
  logic [31:0] x_q       [SLOTS];
  logic [31:0] y_q       [SLOTS];
  int unsigned cur_slot;
  logic        finger_q;

  out_beat_t   expected_events [$];
  out_beat_t   want;
  int          err_count = 0;

  assign fail_count = err_count;

  function automatic out_beat_t make_event(logic [15:0] typ, logic [15:0] code,
                                           logic [31:0] val, logic lst);
    out_beat_t e;
    e.out_type  = typ;
    e.out_code  = code;
    e.out_value = val;
    e.last      = lst;
    return e;
  endfunction

  task automatic track_event(input ev_beat_t b);
    logic [31:0] uval;
    logic [31:0] pv;
    logic        any_active;
    uval = b.ev_value;
    any_active = 1'b0;
    if (b.req_type == REQ_PARSE) begin
      if (b.ev_type == T_ABS) begin
        if (b.ev_code == C_SLOT) begin
          if (uval < 32'(SLOTS)) cur_slot = uval;
        end else if (cur_slot < SLOTS) begin
          touched_q[cur_slot] = 1'b1;
          case (b.ev_code)
            C_TRACK: begin
              track_q[cur_slot]  = uval;
              active_q[cur_slot] = (uval != TRACK_NONE);
            end
            C_PX: begin
              x_q[cur_slot]      = uval;
              active_q[cur_slot] = 1'b1;
            end
            C_PY: begin
              y_q[cur_slot]      = uval;
              active_q[cur_slot] = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (touched_q[i]) begin
          pv = active_q[i] ? 32'd1 : 32'd0;
          expected_events.push_back(make_event(T_ABS, C_SLOT, 32'(i), 1'b0));
          expected_events.push_back(make_event(T_ABS, C_TRACK, track_q[i], 1'b0));
          expected_events.push_back(make_event(T_ABS, C_PX, x_q[i], 1'b0));
          expected_events.push_back(make_event(T_ABS, C_PY, y_q[i], 1'b0));
          expected_events.push_back(make_event(T_ABS, C_MAJOR, pv, 1'b0));
          expected_events.push_back(make_event(T_ABS, C_PRESS, pv, 1'b0));
        end
        touched_q[i] = 1'b0;
        if (active_q[i]) any_active = 1'b1;
      end
      if (any_active && !finger_q) begin
        expected_events.push_back(make_event(T_KEY, C_BTN_TOUCH, 32'd1, 1'b0));
        expected_events.push_back(make_event(T_KEY, C_BTN_FINGER, 32'd1, 1'b0));
        finger_q = 1'b1;
      end else if (!any_active && finger_q) begin
        expected_events.push_back(make_event(T_KEY, C_BTN_TOUCH, 32'd0, 1'b0));
        expected_events.push_back(make_event(T_KEY, C_BTN_FINGER, 32'd0, 1'b0));
        finger_q = 1'b0;
      end
      expected_events.push_back(make_event(T_SYN, C_SYN_REPORT, 32'd0, 1'b1));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i]  = 1'b0;
        touched_q[i] = 1'b0;
        track_q[i]   = TRACK_NONE;
        x_q[i]       = 32'd0;
        y_q[i]       = 32'd0;
      end
      cur_slot = 0;
      finger_q = 1'b0;
      expected_events.delete();
      outstanding <= 0;
    end else begin
      if (rf.valid && rf.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: beat with no expected event: type %h code %h value %h last %b",
                   $time, rf.data.out_type, rf.data.out_code, rf.data.out_value,
                   rf.data.last);
          err_count++;
        end else begin
          want = expected_events.pop_front();
          if (rf.data.out_type !== want.out_type) begin
            $display("%0t: out_type expected %h, actual %h",
                     $time, want.out_type, rf.data.out_type);
            err_count++;
          end
          if (rf.data.out_code !== want.out_code) begin
            $display("%0t: out_code expected %h, actual %h",
                     $time, want.out_code, rf.data.out_code);
            err_count++;
          end
          if (rf.data.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h, actual %h",
                     $time, want.out_value, rf.data.out_value);
            err_count++;
          end
          if (rf.data.last !== want.last) begin
            $display("%0t: last expected %b, actual %b",
                     $time, want.last, rf.data.last);
            err_count++;
          end
        end
      end
      if (ev.valid && ev.ready) track_event(ev.data);
      outstanding <= expected_events.size();
    end
  end

endmodule

@@ tb/mt_b_slot_tracker_reframer_top_tb.sv @@
`timescale 1ns / 100ps
// Stimulus, receiver stalls and verdict for the multitouch slot reframer.
module mt_b_slot_tracker_reframer_top_tb import mtb_pkg::*; ();

  localparam int SLOTS = 10;
  localparam int RANDOM_ITEMS = 150;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   outstanding;

  mtb_ev_if  ev_ch ();
  mtb_out_if out_ch ();

  mt_b_slot_tracker_reframer_top #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .events   (ev_ch),
    .reframed (out_ch)
  );

  mtb_reframe_check #(.SLOTS(SLOTS)) u_check (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev_ch),
    .rf          (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   rx_phase = 0;
  logic rx_next;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rx_next = 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        rx_next = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(8, 80);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
          0: rx_next = 1'b1;
          1: rx_next = 1'($urandom_range(0, 1));
          2: rx_next = (rx_phase % 3) != 0;
          default: rx_next = (rx_phase % 5) == 0;
        endcase
      end
      out_ch.ready <= rx_next;
    end
  end

  int burst_left = 0;
  int counted = 0;

  task automatic send_event(input logic req, input logic [15:0] typ,
                            input logic [15:0] code, input logic [31:0] val);
    ev_beat_t b;
    int gap;
    b.req_type = req;
    b.ev_type  = typ;
    b.ev_code  = code;
    b.ev_value = val;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        ev_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
    end
    ev_ch.valid <= 1'b1;
    ev_ch.data  <= b;
    do @(posedge clk); while (!ev_ch.ready);
    burst_left--;
    if (req == REQ_FLUSH || typ == T_ABS) counted++;
  endtask

  task automatic send_flush();
    send_event(REQ_FLUSH, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic send_frame(input int nslots, input logic with_slot, input logic with_flush);
    int first;
    int sel;
    logic [31:0] val;
    for (int n = 0; n < nslots; n++) begin
      if (with_slot) send_event(REQ_PARSE, T_ABS, C_SLOT, $urandom_range(0, SLOTS - 1));
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        sel = (first + k) % 3;
        if ($urandom_range(0, 3) != 0) begin
          case (sel)
            0: begin
              val = ($urandom_range(0, 3) == 0) ? TRACK_NONE : $urandom;
              send_event(REQ_PARSE, T_ABS, C_TRACK, val);
            end
            1: send_event(REQ_PARSE, T_ABS, C_PX, $urandom);
            default: send_event(REQ_PARSE, T_ABS, C_PY, $urandom);
          endcase
        end
      end
    end
    if (with_flush) send_flush();
  endtask

  task automatic send_noise();
    logic [15:0] typ;
    logic [31:0] val;
    case ($urandom_range(0, 3))
      0: begin
        typ = 16'($urandom);
        if (typ == T_ABS) typ = 16'hfffc;
        send_event(REQ_PARSE, typ, ($urandom_range(0, 1) == 1) ? C_PX : 16'($urandom),
                   $urandom);
      end
      1: begin
        case ($urandom_range(0, 2))
          0: val = $urandom_range(SLOTS, SLOTS + 20);
          1: val = $urandom | 32'h8000_0000;
          default: val = $urandom_range(SLOTS, 32'hffff_ffff);
        endcase
        send_event(REQ_PARSE, T_ABS, C_SLOT, val);
      end
      2: send_event(REQ_PARSE, T_ABS, 16'($urandom), $urandom);
      default: send_flush();
    endcase
  endtask

  int start_count;

  initial begin
    rst = 1'b1;
    ev_ch.valid <= 1'b0;
    ev_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_flush();
    send_event(REQ_PARSE, T_ABS, C_SLOT, SLOTS - 1);
    send_event(REQ_PARSE, T_ABS, C_TRACK, 32'h7fff_ffff);
    send_event(REQ_PARSE, T_ABS, C_PX, 32'h8000_0000);
    send_event(REQ_PARSE, T_ABS, C_PY, 32'h7fff_ffff);
    send_flush();
    send_event(REQ_PARSE, T_ABS, C_SLOT, SLOTS);
    send_event(REQ_PARSE, T_ABS, C_TRACK, TRACK_NONE);
    send_event(REQ_PARSE, T_ABS, C_SLOT, 32'hffff_ffff);
    send_event(REQ_PARSE, T_ABS, C_MAJOR, 32'h1234_5678);
    send_flush();
    send_event(REQ_PARSE, 16'hffff, C_PX, 32'h0000_0055);
    send_event(REQ_PARSE, T_SYN, C_SLOT, 32'd2);
    send_event(REQ_PARSE, T_ABS, C_SLOT, 32'd0);
    send_event(REQ_PARSE, T_ABS, 16'hffff, 32'hdead_beef);
    send_event(REQ_FLUSH, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_event(REQ_PARSE, T_ABS, C_PX, 32'd5);
    send_event(REQ_PARSE, T_ABS, C_SLOT, 32'd3);
    send_event(REQ_PARSE, T_ABS, C_PY, 32'd7);
    send_event(REQ_FLUSH, 16'h0000, 16'h0000, 32'h0000_0000);
    send_flush();

    start_count = counted;
    hold_req <= 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      send_event(REQ_PARSE, T_ABS, C_SLOT, s);
      send_event(REQ_PARSE, T_ABS, C_TRACK, TRACK_NONE);
    end
    send_flush();
    send_frame(2, 1'b1, 1'b1);

    while (counted - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_frame($urandom_range(1, 4), 1'b1, 1'b1);
        6: send_frame($urandom_range(1, 2), 1'b0, 1'($urandom_range(0, 1)));
        7: send_frame(1, 1'b1, 1'b0);
        default: send_noise();
      endcase
    end
    send_flush();
    ev_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ mt_b_slot_tracker_reframer_top.f @@
hw/rtl/mtb_pkg.sv
hw/rtl/mtb_ev_if.sv
hw/rtl/mtb_out_if.sv
hw/rtl/mtb_ram.sv
hw/rtl/mtb_parser.sv
hw/rtl/mtb_flush.sv
hw/rtl/mt_b_slot_tracker_reframer_top.sv
tb/mtb_reframe_check.sv
tb/mt_b_slot_tracker_reframer_top_tb.sv
